// ----- hdl/lcdws_pkg.sv -----
// Shared types and constants for the character-LCD write sequencer.
// No dependencies; every other file in the block imports this package.
package lcdws_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_CMD  = 2'd0,
    MODE_DATA = 2'd1,
    MODE_INT  = 2'd2,
    MODE_INIT = 2'd3
  } mode_t;

  // One input request
  typedef struct packed {
    mode_t              mode;
    logic [7:0]         byte_value;
    logic signed [15:0] number;
  } req_t;

  // One LCD bus write
  typedef struct packed {
    logic       select_data;
    logic [7:0] bus_byte;
    logic       long_wait;
    logic       last_write;
  } wr_t;

  // Classified request as queued between front and back
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  byte_value;
    logic        neg;
    logic [15:0] mag;
  } job_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic push;
    logic full;
  } qin_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } qout_ctl_t;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [2:0] INIT_LAST   = 3'd4;
  localparam logic [2:0] DIGIT_LAST  = 3'd5;

  // Fixed power-on command sequence
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h38;
      3'd1:    c = 8'h0F;
      3'd2:    c = 8'h06;
      3'd3:    c = 8'h03;
      default: c = 8'h01;
    endcase
    return c;
  endfunction

  // k times the decimal weight of digit step s (step 1 is the ten-thousands)
  function automatic logic [16:0] digit_thresh(input logic [2:0] s, input logic [3:0] k);
    logic [16:0] kk;
    logic [16:0] t;
    kk = {13'd0, k};
    case (s)
      3'd1:    t = kk * 17'd10000;
      3'd2:    t = kk * 17'd1000;
      3'd3:    t = kk * 17'd100;
      3'd4:    t = kk * 17'd10;
      default: t = kk;
    endcase
    return t;
  endfunction

endpackage

// ----- hdl/lcdws_front.sv -----
// Front end: accepts requests and classifies them into queue jobs.
// Depends on lcdws_pkg.
module lcdws_front
  import lcdws_pkg::*;
(
  input  logic     start,
  output logic     busy,
  input  req_t     in_req,
  input  logic     q_full,
  output qin_ctl_t q_ctl,
  output job_t     q_job
);

  logic accept;

  // Hold off new requests only while the queue has no room
  assign busy   = q_full;
  assign accept = start & ~q_full;

  // Split the integer into sign and magnitude; 0 - 0x8000 wraps to 32768
  always_comb begin
    q_job.mode       = in_req.mode;
    q_job.byte_value = in_req.byte_value;
    q_job.neg        = (in_req.mode == MODE_INT) && in_req.number[15];
    q_job.mag        = q_job.neg ? (16'd0 - in_req.number) : in_req.number;
  end

  assign q_ctl.push = accept;
  assign q_ctl.full = q_full;

endmodule

// ----- hdl/lcdws_queue.sv -----
// Short job queue between front and back ends, register based.
// Depends on lcdws_pkg.
module lcdws_queue
  import lcdws_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  qin_ctl_t  wr_ctl,
  input  job_t      wr_job,
  input  logic      rd_pop,
  output qout_ctl_t rd_ctl,
  output job_t      rd_job,
  output logic      full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign do_push  = wr_ctl.push & ~full;
  assign do_pop   = rd_pop & (cnt_r != '0);

  // Advance pointers with wrap, track fill
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store payload, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wr_job;
    end
  end

  assign rd_job       = slot_r[rptr_r];
  assign rd_ctl.empty = (cnt_r == '0);
  assign rd_ctl.pop   = do_pop;

endmodule

// ----- hdl/lcdws_back.sv -----
// Back end: walks each queued job and emits its LCD bus writes, one per cycle.
// Depends on lcdws_pkg.
module lcdws_back
  import lcdws_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  qout_ctl_t q_ctl,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_strobe,
  output wr_t       out_write
);

  logic        act_r, act_nxt;
  mode_t       mode_r, mode_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        strobe_r;
  wr_t         write_r;

  wr_t         cur_wr;
  logic [3:0]  digit;
  logic [16:0] sub;
  logic [16:0] rem_ext;
  logic        take;

  // Find the current decimal digit by comparing against its nine multiples
  always_comb begin
    rem_ext = {1'b0, rem_r};
    digit   = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_ext >= digit_thresh(step_r, 4'(k))) begin
        digit = 4'(k);
      end
    end
    sub = digit_thresh(step_r, digit);
  end

  // Form the write for the current step
  always_comb begin
    cur_wr = '0;
    unique case (mode_r)
      MODE_CMD: begin
        cur_wr.bus_byte   = byte_r;
        cur_wr.long_wait  = byte_r[1];
        cur_wr.last_write = 1'b1;
      end
      MODE_DATA: begin
        cur_wr.select_data = 1'b1;
        cur_wr.bus_byte    = byte_r;
        cur_wr.last_write  = 1'b1;
      end
      MODE_INT: begin
        cur_wr.select_data = 1'b1;
        cur_wr.bus_byte    = (step_r == 3'd0) ? ASCII_MINUS : (ASCII_ZERO + {4'd0, digit});
        cur_wr.last_write  = (step_r == DIGIT_LAST);
      end
      MODE_INIT: begin
        cur_wr.bus_byte   = init_cmd(step_r);
        cur_wr.long_wait  = cur_wr.bus_byte[1];
        cur_wr.last_write = (step_r == INIT_LAST);
      end
      default: cur_wr = '0;
    endcase
  end

  // Load the next job when idle or as the current one ends; else end the job or advance the step
  always_comb begin
    take     = (~act_r | cur_wr.last_write) & ~q_ctl.empty;
    act_nxt  = act_r;
    mode_nxt = mode_r;
    byte_nxt = byte_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    if (take) begin
      act_nxt  = 1'b1;
      mode_nxt = q_job.mode;
      byte_nxt = q_job.byte_value;
      rem_nxt  = q_job.mag;
      step_nxt = ((q_job.mode == MODE_INT) && !q_job.neg) ? 3'd1 : 3'd0;
    end else if (act_r && cur_wr.last_write) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      step_nxt = step_r + 3'd1;
      if ((mode_r == MODE_INT) && (step_r != 3'd0)) begin
        rem_nxt = rem_r - sub[15:0];
      end
    end
  end

  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      act_r    <= act_nxt;
      strobe_r <= act_r;
    end
  end

  // Hold job payload and registered result
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    byte_r  <= byte_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    write_r <= cur_wr;
  end

  assign out_strobe = strobe_r;
  assign out_write  = write_r;

endmodule

// ----- hdl/char_lcd_write_sequencer.sv -----
// Top level of the character-LCD write sequencer: front end, job queue, back end.
// Depends on lcdws_pkg, lcdws_front, lcdws_queue and lcdws_back.
//
// A request is taken when start is high and busy is low; busy rises only while
// the job queue is full. Each request produces its LCD writes on out_write, one
// per cycle with out_strobe high for that cycle: one write for a command or data
// byte, five or six for a signed integer (optional '-' then five digits), five
// for the init sequence. The last write of a request has last_write set. When the
// back end is free, the first write passes through the queue, the back end's job
// registers and its output register; consecutive requests follow with no gap,
// paced by the back end's one-write-per-cycle step counter.
// The receiver cannot stall the results; each write must be taken when strobed.
module char_lcd_write_sequencer
  import lcdws_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_strobe,
  output wr_t  out_write
);

  qin_ctl_t  qin_ctl;
  qout_ctl_t qout_ctl;
  job_t      push_job;
  job_t      head_job;
  logic      q_full;
  logic      q_pop;

  lcdws_front u_front (
    .start  (start),
    .busy   (busy),
    .in_req (in_req),
    .q_full (q_full),
    .q_ctl  (qin_ctl),
    .q_job  (push_job)
  );

  lcdws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_ctl (qin_ctl),
    .wr_job (push_job),
    .rd_pop (q_pop),
    .rd_ctl (qout_ctl),
    .rd_job (head_job),
    .full   (q_full)
  );

  lcdws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_ctl      (qout_ctl),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_write  (out_write)
  );

endmodule

// ----- tb/char_lcd_write_sequencer_tb.sv -----
// Self-checking testbench for char_lcd_write_sequencer: directed and random requests,
// every LCD bus write checked against a behavioral prediction of the write list.
// Depends on lcdws_pkg and the char_lcd_write_sequencer RTL.
`timescale 1ns / 1ps

module char_lcd_write_sequencer_tb;
  import lcdws_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_strobe;
  wr_t  out_write;

  // Predicted bus writes, oldest first
  wr_t pending_writes[$];

  int unsigned fail_count;
  int unsigned requests_sent;
  int unsigned writes_seen;
  int unsigned gap_pct;

  char_lcd_write_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_write (out_write)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Append one bus write to the prediction
  function automatic void add_write(input logic sel, input logic [7:0] b, input logic last);
    wr_t w;
    w.select_data = sel;
    w.bus_byte    = b;
    w.long_wait   = (sel == 1'b0) ? b[1] : 1'b0;
    w.last_write  = last;
    pending_writes.push_back(w);
  endfunction

  // Expand one accepted request into the LCD writes it causes
  function automatic void queue_lcd_writes(input req_t r);
    logic [7:0]  init_seq[5];
    int unsigned weights[5];
    logic [16:0] mag;
    int unsigned digit;
    init_seq = '{8'h38, 8'h0F, 8'h06, 8'h03, 8'h01};
    weights  = '{10000, 1000, 100, 10, 1};
    case (r.mode)
      MODE_CMD:  add_write(1'b0, r.byte_value, 1'b1);
      MODE_DATA: add_write(1'b1, r.byte_value, 1'b1);
      MODE_INT: begin
        mag = {1'b0, r.number};
        // Magnitude at 17 bits so the most negative value does not overflow
        if (r.number[15]) begin
          mag = 17'h10000 - {1'b0, r.number};
          add_write(1'b1, 8'h2D, 1'b0);
        end
        for (int i = 0; i < 5; i++) begin
          digit = (int'(mag) / weights[i]) % 10;
          add_write(1'b1, 8'(digit + 48), i == 4);
        end
      end
      default: begin
        for (int i = 0; i < 5; i++) add_write(1'b0, init_seq[i], i == 4);
      end
    endcase
  endfunction

  // Record accepted requests and check each strobed write against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        writes_seen++;
        if (pending_writes.size() == 0) begin
          $error("unexpected write: select_data=%0d bus_byte=%02h long_wait=%0d last_write=%0d",
                 out_write.select_data, out_write.bus_byte, out_write.long_wait,
                 out_write.last_write);
          fail_count++;
        end else begin
          wr_t exp_w;
          exp_w = pending_writes.pop_front();
          if (out_write.select_data !== exp_w.select_data) begin
            $error("select_data: expected %0d, got %0d", exp_w.select_data,
                   out_write.select_data);
            fail_count++;
          end
          if (out_write.bus_byte !== exp_w.bus_byte) begin
            $error("bus_byte: expected %02h, got %02h", exp_w.bus_byte, out_write.bus_byte);
            fail_count++;
          end
          if (out_write.long_wait !== exp_w.long_wait) begin
            $error("long_wait: expected %0d, got %0d", exp_w.long_wait, out_write.long_wait);
            fail_count++;
          end
          if (out_write.last_write !== exp_w.last_write) begin
            $error("last_write: expected %0d, got %0d", exp_w.last_write,
                   out_write.last_write);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        requests_sent++;
        queue_lcd_writes(in_req);
      end
    end
  end

  // Present one request and hold it until the block takes it
  task automatic issue_request(input req_t r);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
  endtask

  function automatic req_t make_req(input mode_t m, input logic [7:0] b,
                                    input logic [15:0] n);
    req_t r;
    r.mode       = m;
    r.byte_value = b;
    r.number     = n;
    return r;
  endfunction

  // Command bytes at the extremes and with the long-wait bit set or clear
  task automatic test_command_writes();
    issue_request(make_req(MODE_CMD, 8'h00, 16'hFFFF));
    issue_request(make_req(MODE_CMD, 8'hFF, 16'h0000));
    issue_request(make_req(MODE_CMD, 8'h02, 16'h1234));
    issue_request(make_req(MODE_CMD, 8'hFD, 16'h8000));
  endtask

  // Data bytes: long_wait must stay low even with bit 1 set
  task automatic test_data_writes();
    issue_request(make_req(MODE_DATA, 8'h00, 16'hFFFF));
    issue_request(make_req(MODE_DATA, 8'hFF, 16'h0000));
    issue_request(make_req(MODE_DATA, 8'h02, 16'h7FFF));
  endtask

  // Integers: zero, extremes, most negative, small values, and digit boundaries
  task automatic test_integer_prints();
    issue_request(make_req(MODE_INT, 8'hFF, 16'd0));
    issue_request(make_req(MODE_INT, 8'h00, 16'h7FFF));
    issue_request(make_req(MODE_INT, 8'hA5, 16'h8000));
    issue_request(make_req(MODE_INT, 8'h5A, 16'hFFFF));
    issue_request(make_req(MODE_INT, 8'h00, 16'd1));
    issue_request(make_req(MODE_INT, 8'h00, 16'd10000));
    issue_request(make_req(MODE_INT, 8'h00, 16'd9999));
    issue_request(make_req(MODE_INT, 8'h00, -16'sd10000));
    issue_request(make_req(MODE_INT, 8'h00, -16'sd8001));
  endtask

  // Init sequence with unused fields at both extremes
  task automatic test_init_sequence();
    issue_request(make_req(MODE_INIT, 8'hFF, 16'hFFFF));
    issue_request(make_req(MODE_INIT, 8'h00, 16'h0000));
  endtask

  // Random request mix with the given sender idle rate
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
    req_t        r;
    int unsigned pick;
    gap_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 25)      r.mode = MODE_CMD;
      else if (pick < 50) r.mode = MODE_DATA;
      else if (pick < 85) r.mode = MODE_INT;
      else                r.mode = MODE_INIT;
      r.byte_value = 8'($urandom);
      r.number     = 16'($urandom);
      // Pull some integers toward digit-count boundaries
      if (r.mode == MODE_INT && $urandom_range(3) == 0) begin
        r.number = 16'($urandom_range(0, 20000) - 10000);
      end
      issue_request(r);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req        = '0;
    fail_count    = 0;
    requests_sent = 0;
    writes_seen   = 0;
    gap_pct       = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_command_writes();
    test_data_writes();
    gap_pct = 40;
    test_integer_prints();
    test_init_sequence();
    test_random_traffic(0, 28);
    test_random_traffic(58, 27);
    test_random_traffic(27, 27);

    // Drain: wait for every predicted write, then watch for stragglers
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests (command, data, integer, init) producing %0d bus writes,",
             requests_sent, writes_seen);
    $display("with sender idle rates of 0, 58 and 27 percent; %0d mismatches.", fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lcdws_pkg.sv
hdl/lcdws_front.sv
hdl/lcdws_queue.sv
hdl/lcdws_back.sv
hdl/char_lcd_write_sequencer.sv
tb/char_lcd_write_sequencer_tb.sv
